>>> sv/hpr_pkg.sv
// ----------------------------------------------------------------------------
// hpr_pkg
// Shared types, constants and the curve colour table of the plot rasterizer.
// ----------------------------------------------------------------------------
package hpr_pkg;

   localparam int DEF_PLOT_BINS  = 256;
   localparam int DEF_MAX_ROWS   = 256;
   localparam int DEF_NUM_CURVES = 6;
   localparam int KNOWN_CURVES   = 6;

   localparam int OP_W       = 2;
   localparam int CHANNEL_W  = 3;
   localparam int BIN_W      = 8;
   localparam int VALUE_W    = 16;
   localparam int READ_ROW_W = 8;
   localparam int READ_COL_W = 7;
   localparam int PIXEL_W    = 8;
   localparam int NIBBLE_W   = 4;

   // widest row and byte-column indexes over the parameter range
   localparam int ROW_MAX_W = 10;
   localparam int COL_MAX_W = 9;
   localparam int DIFF_W    = 18;
   localparam int PREV_W    = 8;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_LSB = 2;

   localparam int HEIGHT_W = 9;
   localparam int STYLE_W  = 2;
   localparam int ENABLE_W = 6;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 9'd256;
   localparam logic [STYLE_W-1:0]  STYLE_RESET  = 2'd2;
   localparam logic [ENABLE_W-1:0] ENABLE_RESET = 6'd57;
   localparam logic [PREV_W-1:0]   PREV_RESET   = 8'hFF;

   localparam int STYLE_BAR_BIT     = 0;
   localparam int STYLE_CONNECT_BIT = 1;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_PLOT  = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [CSR_ADDR_W-CSR_IDX_LSB-1:0] {
      CSR_PLOT_HEIGHT    = 2'd0,
      CSR_DRAW_STYLE     = 2'd1,
      CSR_CHANNEL_ENABLE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_DRAW,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic                   in_range;
      logic [ROW_MAX_W-1:0]   row_lo;
      logic [ROW_MAX_W-1:0]   row_hi;
      logic [COL_MAX_W-1:0]   col;
      logic [PIXEL_W-1:0]     mask;
   } cmd_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] plot_height;
      logic [STYLE_W-1:0]  draw_style;
      logic [ENABLE_W-1:0] channel_enable;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_DRAW,
      ST_FLUSH,
      ST_READ,
      ST_RESULT
   } back_state_type;

   function automatic logic [NIBBLE_W-1:0] curve_colour(input logic [CHANNEL_W-1:0] ch);
      logic [NIBBLE_W-1:0] c;
      case (ch)
         3'd0:    c = 4'd1;
         3'd1:    c = 4'd2;
         3'd2:    c = 4'd2;
         3'd3:    c = 4'd4;
         3'd4:    c = 4'd7;
         3'd5:    c = 4'd2;
         default: c = 4'd0;
      endcase
      return c;
   endfunction

endpackage

>>> sv/hpr_if.sv
// ----------------------------------------------------------------------------
// hpr_if
// Valid/ready channels for plot requests and responses.
// ----------------------------------------------------------------------------
interface hpr_req_if import hpr_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              operation;
   logic [CHANNEL_W-1:0]         channel;
   logic [BIN_W-1:0]             bin;
   logic signed [VALUE_W-1:0]    bin_value;
   logic [READ_ROW_W-1:0]        read_row;
   logic [READ_COL_W-1:0]        read_column;

   modport source (output valid, operation, channel, bin, bin_value, read_row,
                   read_column, input ready);
   modport sink   (input valid, operation, channel, bin, bin_value, read_row,
                   read_column, output ready);
endinterface

interface hpr_rsp_if import hpr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_byte;
   logic               is_read_data;

   modport source (output valid, pixel_byte, is_read_data, input ready);
   modport sink   (input valid, pixel_byte, is_read_data, output ready);
endinterface

>>> sv/histogram_plot_rasterizer.sv
// ----------------------------------------------------------------------------
// histogram_plot_rasterizer
// Rasterizes histogram curves into a packed 4-bit palette image held in an
// on-chip store; clear, plot-bin and read-byte operations.
// ----------------------------------------------------------------------------
//   port       direction  handshake          carries
//   req_bus    in         valid/ready        operation, channel, bin, bin_value,
//                                            read_row, read_column
//   rsp_bus    out        valid/ready        pixel_byte, is_read_data
//   p*         in/out     APB setup/access   plot_height, draw_style,
//                                            channel_enable
//
// A plot does one image read-modify-write per row of its span, an in-range
// read one byte read; a clear writes one byte per cycle over the whole store,
// 32768 bytes at default size.
// After reset the same sweep runs and req_bus is not ready.
// A two-entry command queue and the response register let requests be taken
// while a response waits.
// ----------------------------------------------------------------------------
module histogram_plot_rasterizer import hpr_pkg::*; #(
   parameter int PLOT_BINS  = DEF_PLOT_BINS,
   parameter int MAX_ROWS   = DEF_MAX_ROWS,
   parameter int NUM_CURVES = DEF_NUM_CURVES
) (
   input  logic                  clock,
   input  logic                  reset,
   hpr_req_if.sink               req_bus,
   hpr_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   logic    init_busy;
   logic    push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_data, pop_data;

   hpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hpr_front #(
      .PLOT_BINS  (PLOT_BINS),
      .MAX_ROWS   (MAX_ROWS),
      .NUM_CURVES (NUM_CURVES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .cfg        (cfg),
      .init_busy  (init_busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   hpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   hpr_back #(
      .PLOT_BINS (PLOT_BINS),
      .MAX_ROWS  (MAX_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .init_busy (init_busy),
      .rsp       (rsp_bus)
   );

endmodule

>>> sv/hpr_csr.sv
// ----------------------------------------------------------------------------
// hpr_csr
// APB-style register file: plot height, draw style and channel enables.
// ----------------------------------------------------------------------------
module hpr_csr import hpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [HEIGHT_W-1:0] plot_height_ff, plot_height_in;
   logic [STYLE_W-1:0]  draw_style_ff, draw_style_in;
   logic [ENABLE_W-1:0] channel_enable_ff, channel_enable_in;
   logic [CSR_ADDR_W-CSR_IDX_LSB-1:0] idx;
   logic                wr;

   assign pready = 1'b1;
   assign idx    = paddr[CSR_ADDR_W-1:CSR_IDX_LSB];
   assign wr     = psel && penable && pwrite;

   always_comb begin
      plot_height_in    = plot_height_ff;
      draw_style_in     = draw_style_ff;
      channel_enable_in = channel_enable_ff;
      if (wr) begin
         unique case (idx)
            CSR_PLOT_HEIGHT:    plot_height_in    = pwdata[HEIGHT_W-1:0];
            CSR_DRAW_STYLE:     draw_style_in     = pwdata[STYLE_W-1:0];
            CSR_CHANNEL_ENABLE: channel_enable_in = pwdata[ENABLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_PLOT_HEIGHT:    prdata = CSR_DATA_W'(plot_height_ff);
         CSR_DRAW_STYLE:     prdata = CSR_DATA_W'(draw_style_ff);
         CSR_CHANNEL_ENABLE: prdata = CSR_DATA_W'(channel_enable_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plot_height_ff    <= HEIGHT_RESET;
         draw_style_ff     <= STYLE_RESET;
         channel_enable_ff <= ENABLE_RESET;
      end else begin
         plot_height_ff    <= plot_height_in;
         draw_style_ff     <= draw_style_in;
         channel_enable_ff <= channel_enable_in;
      end
   end

   assign cfg.plot_height    = plot_height_ff;
   assign cfg.draw_style     = draw_style_ff;
   assign cfg.channel_enable = channel_enable_ff;

endmodule

>>> sv/hpr_front.sv
// ----------------------------------------------------------------------------
// hpr_front
// Takes request transactions, clamps the point row, works out the row span
// to draw and keeps the previous point of the curve.
// ----------------------------------------------------------------------------
module hpr_front import hpr_pkg::*; #(
   parameter int PLOT_BINS  = DEF_PLOT_BINS,
   parameter int MAX_ROWS   = DEF_MAX_ROWS,
   parameter int NUM_CURVES = DEF_NUM_CURVES
) (
   input  logic       clock,
   input  logic       reset,
   hpr_req_if.sink    req,
   input  cfg_type    cfg,
   input  logic       init_busy,
   output logic       push_valid,
   input  logic       push_ready,
   output cmd_type    push_data
);

   localparam int ROW_BYTES = PLOT_BINS / 2;
   localparam logic signed [DIFF_W-1:0] ONE_E      = DIFF_W'(1);
   localparam logic signed [DIFF_W-1:0] MAX_ROWS_E = DIFF_W'(MAX_ROWS);
   localparam logic signed [DIFF_W-1:0] ROW_LAST_E = DIFF_W'(MAX_ROWS - 1);
   localparam int EN_N = 1 << CHANNEL_W;

   logic                       item_valid_ff, item_valid_in;
   op_type                     operation_ff;
   logic [CHANNEL_W-1:0]       channel_ff;
   logic [BIN_W-1:0]           bin_ff;
   logic signed [VALUE_W-1:0]  value_ff;
   logic [READ_ROW_W-1:0]      read_row_ff;
   logic [READ_COL_W-1:0]      read_col_ff;
   logic [PREV_W-1:0]          prev_ff, prev_in;

   logic accept, push;
   logic signed [DIFF_W-1:0] ph_e, h_e, hm1_e, v_e, diff_e, d_e, last_e, lo_e, hi_e;
   logic [PREV_W-1:0]        prev_start;
   logic [EN_N-1:0]          en_vec;
   logic                     bar, conn, enabled, plot_ok, draw_ok, read_ok;
   logic [BIN_W-2:0]         bin_col;
   logic [NIBBLE_W-1:0]      colour;

   assign req.ready     = !init_busy && (!item_valid_ff || push_ready);
   assign accept        = req.valid && req.ready;
   assign push_valid    = item_valid_ff;
   assign push          = item_valid_ff && push_ready;
   assign item_valid_in = accept ? 1'b1 : (push ? 1'b0 : item_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         prev_ff       <= PREV_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         prev_ff       <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         operation_ff <= op_type'(req.operation);
         channel_ff   <= req.channel;
         bin_ff       <= req.bin;
         value_ff     <= req.bin_value;
         read_row_ff  <= req.read_row;
         read_col_ff  <= req.read_column;
      end
   end

   // point row and span
   always_comb begin
      ph_e = $signed({{(DIFF_W-HEIGHT_W){1'b0}}, cfg.plot_height});
      if (ph_e == '0) begin
         h_e = ONE_E;
      end else if (ph_e > MAX_ROWS_E) begin
         h_e = MAX_ROWS_E;
      end else begin
         h_e = ph_e;
      end
      hm1_e  = h_e - ONE_E;
      v_e    = $signed({{(DIFF_W-VALUE_W){value_ff[VALUE_W-1]}}, value_ff});
      diff_e = hm1_e - v_e;
      if (diff_e < 0) begin
         d_e = '0;
      end else if (diff_e > hm1_e) begin
         d_e = hm1_e;
      end else begin
         d_e = diff_e;
      end

      prev_start = (bin_ff == '0) ? hm1_e[PREV_W-1:0] : prev_ff;
      last_e     = $signed({{(DIFF_W-PREV_W){1'b0}}, prev_start});
      bar        = cfg.draw_style[STYLE_BAR_BIT];
      conn       = !bar && cfg.draw_style[STYLE_CONNECT_BIT];

      lo_e = d_e;
      hi_e = d_e;
      if (bar) begin
         hi_e = hm1_e;
      end else if (conn) begin
         if (last_e > d_e) begin
            hi_e = last_e - ONE_E;
         end else if (last_e < d_e) begin
            lo_e = last_e + ONE_E;
         end
      end
      if (hi_e > ROW_LAST_E) begin
         hi_e = ROW_LAST_E;
      end
   end

   // classification
   always_comb begin
      en_vec  = EN_N'(cfg.channel_enable);
      enabled = en_vec[channel_ff] && (int'(channel_ff) < NUM_CURVES)
                && (int'(channel_ff) < KNOWN_CURVES);
      bin_col = bin_ff[BIN_W-1:1];
      plot_ok = (operation_ff == OP_PLOT) && enabled && (int'(bin_ff) < PLOT_BINS);
      draw_ok = plot_ok && (int'(bin_col) < ROW_BYTES);
      read_ok = (int'(read_row_ff) < MAX_ROWS) && (int'(read_col_ff) < ROW_BYTES);
      colour  = curve_colour(channel_ff);

      prev_in = prev_ff;
      if (push && plot_ok) begin
         prev_in = conn ? d_e[PREV_W-1:0] : prev_start;
      end

      push_data = '0;
      unique case (operation_ff)
         OP_CLEAR: begin
            push_data.kind = CMD_CLEAR;
         end
         OP_PLOT: begin
            push_data.kind   = draw_ok ? CMD_DRAW : CMD_NONE;
            push_data.row_lo = lo_e[ROW_MAX_W-1:0];
            push_data.row_hi = hi_e[ROW_MAX_W-1:0];
            push_data.col    = COL_MAX_W'(bin_col);
            push_data.mask   = bin_ff[0] ? {{NIBBLE_W{1'b0}}, colour}
                                         : {colour, {NIBBLE_W{1'b0}}};
         end
         OP_READ: begin
            push_data.kind     = CMD_READ;
            push_data.in_range = read_ok;
            push_data.row_lo   = ROW_MAX_W'(read_row_ff);
            push_data.col      = COL_MAX_W'(read_col_ff);
         end
         default: begin
            push_data.kind = CMD_NONE;
         end
      endcase
   end

endmodule

>>> sv/hpr_queue.sv
// ----------------------------------------------------------------------------
// hpr_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module hpr_queue import hpr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/hpr_back.sv
// ----------------------------------------------------------------------------
// hpr_back
// Image store and its sequencer: clearing sweeps, column read-modify-write
// spans, byte reads and the response register.
// ----------------------------------------------------------------------------
module hpr_back import hpr_pkg::*; #(
   parameter int PLOT_BINS = DEF_PLOT_BINS,
   parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  cmd_type  pop_data,
   output logic     init_busy,
   hpr_rsp_if.source rsp
);

   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_W     = $clog2(PLOT_BINS / 2);
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;

   logic [PIXEL_W-1:0] image_mem [MEM_DEPTH];

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [ROW_W-1:0]   row_ff, row_in, wrow_ff, wrow_in;
   logic               wpend_ff, wpend_in;
   logic [PIXEL_W-1:0] rdata_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic               rsp_read_ff, rsp_read_in;

   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [PIXEL_W-1:0] mem_wdata;
   logic               rsp_free, rsp_load, sweep_done;
   logic [COL_W-1:0]   cmd_col;
   logic [ROW_W-1:0]   cmd_lo, cmd_hi;

   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign sweep_done = &cnt_ff;
   assign cmd_col    = cmd_ff.col[COL_W-1:0];
   assign cmd_lo     = cmd_ff.row_lo[ROW_W-1:0];
   assign cmd_hi     = cmd_ff.row_hi[ROW_W-1:0];
   assign init_busy  = (state_ff == ST_INIT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:   if (sweep_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (pop_valid) begin
               unique case (pop_data.kind)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_DRAW:  state_in = ST_DRAW;
                  CMD_READ:  state_in = pop_data.in_range ? ST_READ : ST_RESULT;
                  default:   state_in = ST_RESULT;
               endcase
            end
         end
         ST_CLEAR:  if (sweep_done) state_in = ST_RESULT;
         ST_DRAW:   if (row_ff == cmd_hi) state_in = ST_FLUSH;
         ST_FLUSH:  state_in = ST_RESULT;
         ST_READ:   state_in = ST_RESULT;
         ST_RESULT: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      pop_ready = 1'b0;
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      row_in    = row_ff;
      wrow_in   = wrow_ff;
      wpend_in  = wpend_ff;
      mem_we    = 1'b0;
      mem_waddr = {wrow_ff, cmd_col};
      mem_wdata = rdata_ff | cmd_ff.mask;
      mem_re    = 1'b0;
      mem_raddr = {row_ff, cmd_col};
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = '0;
            cnt_in    = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            pop_ready = 1'b1;
            cnt_in    = '0;
            wpend_in  = 1'b0;
            if (pop_valid) begin
               cmd_in = pop_data;
               row_in = pop_data.row_lo[ROW_W-1:0];
            end
         end
         ST_DRAW: begin
            mem_re   = 1'b1;
            mem_we   = wpend_ff;
            wrow_in  = row_ff;
            wpend_in = 1'b1;
            row_in   = row_ff + 1'b1;
         end
         ST_FLUSH: begin
            mem_we = 1'b1;
         end
         ST_READ: begin
            mem_re    = 1'b1;
            mem_raddr = {cmd_lo, cmd_col};
         end
         ST_RESULT: begin
            rsp_load = rsp_free;
         end
         default: ;
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
      rsp_byte_in  = rsp_byte_ff;
      rsp_read_in  = rsp_read_ff;
      if (rsp_load) begin
         rsp_read_in = (cmd_ff.kind == CMD_READ);
         rsp_byte_in = (cmd_ff.kind == CMD_READ && cmd_ff.in_range) ? rdata_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         wpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wpend_ff     <= wpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      wrow_ff     <= wrow_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_read_ff <= rsp_read_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         image_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= image_mem[mem_raddr];
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pixel_byte   = rsp_byte_ff;
   assign rsp.is_read_data = rsp_read_ff;

endmodule
